>>> rtl/core/pc_value_table_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// PC-value table decoder: assertion macros
// Shared assertion wrappers for the decoder core; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PC_VALUE_TABLE_DECODER_CORE_MACROS_SVH
`define PC_VALUE_TABLE_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PVT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pvt assertion failed");
`define PVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvt assertion failed");
`else
`define PVT_ASSERT(label, clk, rst_n, prop)
`define PVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/pvt_pkg.sv
// ----------------------------------------------------------------------------
// PC-value table decoder: package
// Types, codes and constants shared by the decoder core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pvt_pkg;

    localparam int MAX_VARINT_BYTES_DEF = 10;

    localparam logic [2:0]  PC_QUANTUM_RESET = 3'd1;
    localparam logic [31:0] VALUE_ERROR      = 32'hFFFF_FFFF;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_FOUND      = 2'd0,
        STATUS_ZERO_DELTA = 2'd1,
        STATUS_TOO_LONG   = 2'd2
    } status_t;

    typedef struct packed {
        logic        command;
        logic [63:0] entry_pc;
        logic [63:0] target_pc;
        logic [7:0]  table_byte;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        status_t     status;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/pvt_in_stage.sv
// ----------------------------------------------------------------------------
// PC-value table decoder: input stage
// Registers one accepted item and releases it when the result side has room.
// ----------------------------------------------------------------------------
`default_nettype none

module pvt_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire pvt_pkg::item_t in_item,
    input  wire logic           drain,
    output logic                step,
    output pvt_pkg::item_t      item
);
    import pvt_pkg::*;

    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;

    assign step     = item_valid_reg && drain;
    assign in_ready = !item_valid_reg || drain;
    assign item     = item_reg;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (step)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pvt_decoder.sv
// ----------------------------------------------------------------------------
// PC-value table decoder: decode stage
// Varint accumulation, zigzag value update, scaled PC update and target test.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pc_value_table_decoder_core_macros.svh"

module pvt_decoder #(
    parameter int MAX_VARINT_BYTES = pvt_pkg::MAX_VARINT_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire pvt_pkg::item_t item,
    input  wire logic [2:0]     quantum,
    output pvt_pkg::result_t    result
);
    import pvt_pkg::*;

    localparam int CNT_W = $clog2(MAX_VARINT_BYTES);

    logic             busy_reg,       busy_next;
    logic             pc_phase_reg,   pc_phase_next;
    logic             first_pair_reg, first_pair_next;
    logic [63:0]      accum_reg,      accum_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [31:0]      value_reg,      value_next;
    logic [63:0]      pc_reg,         pc_next;
    logic [63:0]      target_reg,     target_next;

    logic [5:0]  shamt;
    logic [63:0] raw;
    logic [31:0] delta;
    logic [63:0] pc_sum;

    assign shamt  = 6'(7 * count_reg);
    assign raw    = accum_reg | ({57'd0, item.table_byte[6:0]} << shamt);
    assign delta  = raw[32:1] ^ {32{raw[0]}};
    assign pc_sum = pc_reg + (raw * {61'd0, quantum});

    always_comb
    begin
        busy_next       = busy_reg;
        pc_phase_next   = pc_phase_reg;
        first_pair_next = first_pair_reg;
        accum_next      = accum_reg;
        count_next      = count_reg;
        value_next      = value_reg;
        pc_next         = pc_reg;
        target_next     = target_reg;
        result.valid    = 1'b0;
        result.value    = VALUE_ERROR;
        result.status   = STATUS_FOUND;
        if (step)
        begin
            if (item.command == CMD_START)
            begin
                busy_next       = 1'b1;
                pc_phase_next   = 1'b0;
                first_pair_next = 1'b1;
                accum_next      = '0;
                count_next      = '0;
                value_next      = VALUE_ERROR;
                pc_next         = item.entry_pc;
                target_next     = item.target_pc;
            end
            else if (busy_reg)
            begin
                if (item.table_byte[7])
                begin
                    if (count_reg == CNT_W'(MAX_VARINT_BYTES - 1))
                    begin
                        busy_next     = 1'b0;
                        result.valid  = 1'b1;
                        result.status = STATUS_TOO_LONG;
                    end
                    else
                    begin
                        accum_next = raw;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    accum_next = '0;
                    count_next = '0;
                    if (!pc_phase_reg)
                    begin
                        if (raw == 64'd0 && !first_pair_reg)
                        begin
                            busy_next     = 1'b0;
                            result.valid  = 1'b1;
                            result.status = STATUS_ZERO_DELTA;
                        end
                        else
                        begin
                            value_next    = value_reg + delta;
                            pc_phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        pc_next         = pc_sum;
                        pc_phase_next   = 1'b0;
                        first_pair_next = 1'b0;
                        if (target_reg < pc_sum)
                        begin
                            busy_next    = 1'b0;
                            result.valid = 1'b1;
                            result.value = value_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pc_phase_reg   <= 1'b0;
            first_pair_reg <= 1'b1;
            accum_reg      <= '0;
            count_reg      <= '0;
            value_reg      <= VALUE_ERROR;
            pc_reg         <= '0;
            target_reg     <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pc_phase_reg   <= pc_phase_next;
            first_pair_reg <= first_pair_next;
            accum_reg      <= accum_next;
            count_reg      <= count_next;
            value_reg      <= value_next;
            pc_reg         <= pc_next;
            target_reg     <= target_next;
        end
    end

    `PVT_ASSERT_NEXT(a_idle_after_result, clk, rst_n, result.valid, !busy_reg)
    `PVT_ASSERT(a_error_value, clk, rst_n, !result.valid || result.status == STATUS_FOUND || result.value == VALUE_ERROR)
    `PVT_ASSERT_NEXT(a_start_clears, clk, rst_n, step && item.command == CMD_START, busy_reg && count_reg == '0 && !pc_phase_reg)

endmodule

`default_nettype wire

>>> rtl/core/pvt_out_stage.sv
// ----------------------------------------------------------------------------
// PC-value table decoder: output stage
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pc_value_table_decoder_core_macros.svh"

module pvt_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pvt_pkg::result_t result,
    output logic                  drain,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [31:0]           value,
    output logic [1:0]            status
);
    import pvt_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg;
    status_t     status_reg;

    assign drain     = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            value_reg  <= result.value;
            status_reg <= result.status;
        end
    end

    `PVT_ASSERT(a_no_overwrite, clk, rst_n, !(result.valid && out_valid_reg && !out_ready))

endmodule

`default_nettype wire

>>> rtl/core/pc_value_table_decoder_core.sv
// ----------------------------------------------------------------------------
// PC-value table decoder core
// Streams a pc-value table byte by byte and reports the value at a target PC.
//
//   Channel   Handshake              Payload
//   cfg       cfg_valid/cfg_ready    pc_quantum
//   in        in_valid/in_ready      command, entry_pc, target_pc, table_byte
//   out       out_valid/out_ready    table_value, lookup_status
//
// One item is accepted every cycle while in_ready is high. An accepted item
// waits in the input register, is decoded, and any result that it yields is
// registered in the output stage.
// Reset clears all control state and sets the quantum to one.
// A stalled output holds its result and the input register; in_ready falls
// only when both are occupied. The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_value_table_decoder_core #(
    parameter int MAX_VARINT_BYTES = pvt_pkg::MAX_VARINT_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         pc_quantum,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               command,
    input  wire logic [63:0]        entry_pc,
    input  wire logic [63:0]        target_pc,
    input  wire logic [7:0]         table_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      table_value,
    output logic [1:0]              lookup_status
);
    import pvt_pkg::*;

    logic [2:0] quantum_reg;
    item_t      in_item;
    item_t      item;
    result_t    result;
    logic       step;
    logic       drain;
    logic [31:0] out_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= PC_QUANTUM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            quantum_reg <= pc_quantum;
        end
    end

    assign in_item.command    = command;
    assign in_item.entry_pc   = entry_pc;
    assign in_item.target_pc  = target_pc;
    assign in_item.table_byte = table_byte;

    pvt_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .drain    (drain),
        .step     (step),
        .item     (item)
    );

    pvt_decoder #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (item),
        .quantum (quantum_reg),
        .result  (result)
    );

    pvt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .drain     (drain),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (out_value),
        .status    (lookup_status)
    );

    assign table_value = signed'(out_value);

endmodule

`default_nettype wire
